// ===== src/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// Block and key types, the forward and inverse S-boxes, round constants and
// the byte-level round and key-schedule functions that the pipeline stages
// share.
// ----------------------------------------------------------------------------
package aes_pkg;

    typedef logic [127:0] t_block;
    typedef logic [7:0]   t_byte;

    // Command codes of the block channel.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Register indexes of the configuration channel.
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    // Stage counts: key pre-expansion stages, then one stage per round step.
    localparam int FRONT_STAGES = 10;
    localparam int ROUND_STAGES = 11;
    localparam int NUM_STAGES   = FRONT_STAGES + ROUND_STAGES;

    // One beat as it travels down the pipeline.
    typedef struct packed {
        logic   cmd;
        t_block data;
        t_block key;
    } t_beat;

    // Round constants, padded with zero at both ends.
    localparam t_byte RCON [12] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
        8'h20, 8'h40, 8'h80, 8'h1b, 8'h36, 8'h00
    };

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte SBOX_REV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Byte n of a block; byte 0 is the most significant.
    function automatic t_byte get_byte(input t_block b, input int n);
        get_byte = b[127 - 8 * n -: 8];
    endfunction

    // Multiply by x in GF(2^8).
    function automatic t_byte xtime(input t_byte x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // General GF(2^8) product, eight shift-and-add steps on a byte.
    function automatic t_byte gmul(input t_byte x, input t_byte y);
        t_byte acc;
        t_byte p;
        acc = 8'h00;
        p   = x;
        for (int b = 0; b < 8; b++) begin
            if (y[b]) begin
                acc = acc ^ p;
            end
            p = xtime(p);
        end
        gmul = acc;
    endfunction

    function automatic t_block sub_bytes(input t_block s);
        t_block t;
        for (int n = 0; n < 16; n++) begin
            t[127 - 8 * n -: 8] = SBOX[get_byte(s, n)];
        end
        sub_bytes = t;
    endfunction

    function automatic t_block inv_sub_bytes(input t_block s);
        t_block t;
        for (int n = 0; n < 16; n++) begin
            t[127 - 8 * n -: 8] = SBOX_REV[get_byte(s, n)];
        end
        inv_sub_bytes = t;
    endfunction

    // Row r rotates left by r columns (or right when inverse).
    function automatic t_block shift_rows(input t_block s, input logic inverse);
        t_block t;
        int     src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inverse ? 4 * ((c + 3 * r) % 4) + r : 4 * ((c + r) % 4) + r;
                t[127 - 8 * (4 * c + r) -: 8] = get_byte(s, src);
            end
        end
        shift_rows = t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block t;
        t_byte  a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            t[127 - 8 * (4 * c)     -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[127 - 8 * (4 * c + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[127 - 8 * (4 * c + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[127 - 8 * (4 * c + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix_columns = t;
    endfunction

    function automatic t_block inv_mix_columns(input t_block s);
        t_block t;
        t_byte  a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            t[127 - 8 * (4 * c) -: 8] =
                gmul(a0, 8'h0e) ^ gmul(a1, 8'h0b) ^ gmul(a2, 8'h0d) ^ gmul(a3, 8'h09);
            t[127 - 8 * (4 * c + 1) -: 8] =
                gmul(a0, 8'h09) ^ gmul(a1, 8'h0e) ^ gmul(a2, 8'h0b) ^ gmul(a3, 8'h0d);
            t[127 - 8 * (4 * c + 2) -: 8] =
                gmul(a0, 8'h0d) ^ gmul(a1, 8'h09) ^ gmul(a2, 8'h0e) ^ gmul(a3, 8'h0b);
            t[127 - 8 * (4 * c + 3) -: 8] =
                gmul(a0, 8'h0b) ^ gmul(a1, 8'h0d) ^ gmul(a2, 8'h09) ^ gmul(a3, 8'h0e);
        end
        inv_mix_columns = t;
    endfunction

    // Next round key from the previous one.
    function automatic t_block key_next(input t_block k, input t_byte rc);
        t_block t;
        t[127:120] = k[127:120] ^ SBOX[k[23:16]] ^ rc;
        t[119:112] = k[119:112] ^ SBOX[k[15:8]];
        t[111:104] = k[111:104] ^ SBOX[k[7:0]];
        t[103:96]  = k[103:96]  ^ SBOX[k[31:24]];
        t[95:64]   = k[95:64] ^ t[127:96];
        t[63:32]   = k[63:32] ^ t[95:64];
        t[31:0]    = k[31:0]  ^ t[63:32];
        key_next = t;
    endfunction

    // Previous round key from the current one; rc is the current key's constant.
    function automatic t_block key_prev(input t_block k, input t_byte rc);
        t_block t;
        t[31:0]    = k[31:0]  ^ k[63:32];
        t[63:32]   = k[63:32] ^ k[95:64];
        t[95:64]   = k[95:64] ^ k[127:96];
        t[127:120] = k[127:120] ^ SBOX[t[23:16]] ^ rc;
        t[119:112] = k[119:112] ^ SBOX[t[15:8]];
        t[111:104] = k[111:104] ^ SBOX[t[7:0]];
        t[103:96]  = k[103:96]  ^ SBOX[t[31:24]];
        key_prev = t;
    endfunction

endpackage

// ===== src/aes_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 channel interfaces
// Valid/ready channels for input blocks, result blocks and key writes.
// ----------------------------------------------------------------------------
interface aes_blk_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, command, data_high, data_low, input ready);
    modport sink   (input valid, command, data_high, data_low, output ready);
endinterface

interface aes_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== src/aes_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 pipeline stage
// One registered stage. Early stages pre-expand the key to the last round key
// for decryption; later stages run one cipher round each, with the round key
// stepped forward or backward alongside the state.
// ----------------------------------------------------------------------------
module aes_stage #(
    parameter int STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  aes_pkg::t_beat i_beat,
    output logic          o_valid,
    output aes_pkg::t_beat o_beat
);
    import aes_pkg::*;

    localparam bit IS_FRONT = (STAGE < FRONT_STAGES);
    localparam int RND      = IS_FRONT ? 0 : STAGE - FRONT_STAGES;
    localparam t_byte RC_FRONT = RCON[IS_FRONT ? STAGE + 1 : 0];
    localparam t_byte RC_ENC   = RCON[RND + 1];
    localparam t_byte RC_DEC   = RCON[10 - RND];

    logic   r_valid;
    t_beat  r_beat;
    t_beat  n_beat;
    t_block w_state;

    // Stage work on the incoming beat.
    always_comb begin
        n_beat  = i_beat;
        w_state = i_beat.data;
        if (IS_FRONT) begin
            // Decryption walks the key forward to the last round key.
            if (i_beat.cmd == CMD_DECRYPT) begin
                n_beat.key = key_next(i_beat.key, RC_FRONT);
            end
        end else if (i_beat.cmd == CMD_ENCRYPT) begin
            if (RND != 0) begin
                w_state = shift_rows(sub_bytes(w_state), 1'b0);
                if (RND < 10) begin
                    w_state = mix_columns(w_state);
                end
            end
            n_beat.data = w_state ^ i_beat.key;
            n_beat.key  = key_next(i_beat.key, RC_ENC);
        end else begin
            if (RND != 0) begin
                w_state = inv_sub_bytes(shift_rows(w_state, 1'b1));
            end
            w_state = w_state ^ i_beat.key;
            if (RND != 0 && RND < 10) begin
                w_state = inv_mix_columns(w_state);
            end
            n_beat.data = w_state;
            n_beat.key  = key_prev(i_beat.key, RC_DEC);
        end
    end

    // Stage registers; valid is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== src/aes128_block_cipher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher core
// Encrypts or decrypts one 128-bit block per beat with the key held in two
// configuration registers, in a fully unrolled 21-stage pipeline.
//
//   Channel  Direction  Carries
//   i_blk    in         command, data_high, data_low
//   o_res    out        result_high, result_low
//   i_cfg    in         index (0 key_high, 1 key_low), wdata
//
// The pipeline has ten key pre-expansion stages, then eleven round
// stages. One block enters per cycle while the output is not stalled.
// Reset clears the stage valid bits and both key registers.
// A stalled output freezes every stage at once, so no beat is lost or
// repeated; the input is ready whenever the last stage is empty or drains.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core (
    input  logic i_clk,
    input  logic i_rst_n,
    aes_blk_if.sink   i_blk,
    aes_res_if.source o_res,
    aes_cfg_if.sink   i_cfg
);
    import aes_pkg::*;

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic        w_en;
    logic        w_valid [NUM_STAGES + 1];
    t_beat       w_beat  [NUM_STAGES + 1];

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_KEY_HIGH: r_key_high <= i_cfg.wdata;
                REG_KEY_LOW:  r_key_low  <= i_cfg.wdata;
                default:      ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Whole pipeline advances unless a finished beat is held at the output.
    assign w_en        = !w_valid[NUM_STAGES] || o_res.ready;
    assign i_blk.ready = w_en;

    assign w_valid[0]     = i_blk.valid;
    assign w_beat[0].cmd  = i_blk.command;
    assign w_beat[0].data = {i_blk.data_high, i_blk.data_low};
    assign w_beat[0].key  = {r_key_high, r_key_low};

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        aes_stage #(
            .STAGE(s)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[s]),
            .i_beat  (w_beat[s]),
            .o_valid (w_valid[s + 1]),
            .o_beat  (w_beat[s + 1])
        );
    end

    assign o_res.valid       = w_valid[NUM_STAGES];
    assign o_res.result_high = w_beat[NUM_STAGES].data[127:64];
    assign o_res.result_low  = w_beat[NUM_STAGES].data[63:0];

endmodule
